// ===== rtl/ebtt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ebtt_pkg;

	// Fixed-point layout: energy is unsigned Q4.12, the baseline carries extra fraction bits.
	localparam int ENERGY_BITS         = 16;
	localparam int BASELINE_EXTRA_BITS = 16;
	localparam int BASELINE_BITS       = ENERGY_BITS + BASELINE_EXTRA_BITS;
	localparam int ALPHA_BITS          = 16;
	localparam int WARMUP_BITS         = 8;
	localparam int COUNT_BITS          = 32;
	localparam int TIME_BITS           = 32;
	localparam int CFG_INDEX_BITS      = 2;
	localparam int CFG_DATA_BITS       = 16;

	localparam logic [15:0] THRESHOLD_RESET = 16'd614;   // 0.15 in Q4.12
	localparam logic [15:0] ALPHA_RESET     = 16'd3277;  // 0.05 in Q0.16
	localparam logic [7:0]  WARMUP_RESET    = 8'd20;

	typedef enum logic [1:0] {
		MODE_IDLE      = 2'd0,
		MODE_ARMED     = 2'd1,
		MODE_TRIGGERED = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		CMD_FEED   = 2'd0,
		CMD_ARM    = 2'd1,
		CMD_DISARM = 2'd2,
		CMD_REARM  = 2'd3
	} cmd_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_ALPHA     = 2'd1,
		REG_WARMUP    = 2'd2,
		REG_UNUSED    = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [1:0]             command;
		logic [ENERGY_BITS-1:0] energy;
		logic [TIME_BITS-1:0]   timestamp;
	} ebtt_in_t;

	typedef struct packed {
		logic                   fired;
		logic [1:0]             machine_state;
		logic                   warmed_up;
		logic [COUNT_BITS-1:0]  fire_count;
		logic [TIME_BITS-1:0]   last_fire_time;
		logic [ENERGY_BITS-1:0] last_fire_energy;
	} ebtt_out_t;

	typedef struct packed {
		logic [ENERGY_BITS-1:0] threshold;
		logic [ALPHA_BITS-1:0]  alpha;
		logic [WARMUP_BITS-1:0] warmup_frames;
	} ebtt_cfg_t;

	typedef struct packed {
		mode_t                    mode;
		logic [BASELINE_BITS-1:0] baseline;
		logic [WARMUP_BITS-1:0]   warmup_count;
		logic                     baseline_ready;
		logic [COUNT_BITS-1:0]    trigger_total;
		logic [TIME_BITS-1:0]     last_time;
		logic [ENERGY_BITS-1:0]   last_energy;
	} ebtt_state_t;

endpackage

`default_nettype wire

// ===== rtl/ema_baseline_transient_trigger_top.sv =====
// EMA baseline transient trigger.
// Input channel (in_valid/in_ready/in_data): one transaction per command -
// feed energy, arm, disarm or rearm - with the frame energy (Q4.12) and a
// timestamp. Output channel (out_valid/out_ready/out_data): exactly one
// result per input transaction, in order: fired flag, state after the
// command, warm-up flag, trigger count and the time and energy of the last
// trigger. Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is
// always ready: index 0 threshold (a zero write is dropped), 1 EMA weight,
// 2 warm-up frame count, 3 ignored. Write it only while the block is idle.
// Path: a transaction lands in the input stage, then its result moves into
// the output register, raising out_valid, once it is free or being drained.
// Throughput: one transaction per cycle while out_ready is high; the
// baseline multiply-add and the threshold compare sit between the input
// stage and the output register, and the state registers update as the
// result is loaded.
// Stall: when out_ready is low the result is held and the input stage keeps
// its transaction; in_ready drops only once both are occupied.
// Reset: state idle, baseline, counters and records zero, registers at their
// defaults (threshold 0.15, weight 0.05, warm-up 20 frames).
`timescale 1ns / 1ps
`default_nettype none

module ema_baseline_transient_trigger_top (
	input  wire                                       clk,
	input  wire                                       arst_n,
	input  wire                                       in_valid,
	output logic                                      in_ready,
	input  ebtt_pkg::ebtt_in_t                        in_data,
	output logic                                      out_valid,
	input  wire                                       out_ready,
	output ebtt_pkg::ebtt_out_t                       out_data,
	input  wire                                       cfg_valid,
	output logic                                      cfg_ready,
	input  wire [ebtt_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
	input  wire [ebtt_pkg::CFG_DATA_BITS-1:0]         cfg_data
);
	import ebtt_pkg::*;

	// input stage
	logic        valid_s1;
	ebtt_in_t    item_s1;

	// architectural state and config
	ebtt_state_t state_q;
	ebtt_state_t state_nxt;
	ebtt_cfg_t   cfg_q;

	// output register
	logic        out_valid_q;
	ebtt_out_t   out_data_q;
	ebtt_out_t   result;

	logic        advance;
	reg_index_t  widx;

	// Move the staged transaction into the output register when it is free
	// or being drained this cycle.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign cfg_ready = 1'b1;
	assign widx      = reg_index_t'(cfg_index);

	ebtt_step u_step (
		.item   (item_s1),
		.cur    (state_q),
		.cfg    (cfg_q),
		.nxt    (state_nxt),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode           <= MODE_IDLE;
			state_q.baseline       <= '0;
			state_q.warmup_count   <= '0;
			state_q.baseline_ready <= 1'b0;
			state_q.trigger_total  <= '0;
			state_q.last_time      <= '0;
			state_q.last_energy    <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Configuration writes; a zero threshold is rejected.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold     <= THRESHOLD_RESET;
			cfg_q.alpha         <= ALPHA_RESET;
			cfg_q.warmup_frames <= WARMUP_RESET;
		end else if (cfg_valid) begin
			case (widx)
				REG_THRESHOLD: begin
					if (cfg_data != '0) begin
						cfg_q.threshold <= cfg_data[ENERGY_BITS-1:0];
					end
				end
				REG_ALPHA: begin
					cfg_q.alpha <= cfg_data[ALPHA_BITS-1:0];
				end
				REG_WARMUP: begin
					cfg_q.warmup_frames <= cfg_data[WARMUP_BITS-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// ===== rtl/ebtt_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Next-state and result logic for one transaction.
module ebtt_step (
	input  ebtt_pkg::ebtt_in_t    item,
	input  ebtt_pkg::ebtt_state_t cur,
	input  ebtt_pkg::ebtt_cfg_t   cfg,
	output ebtt_pkg::ebtt_state_t nxt,
	output ebtt_pkg::ebtt_out_t   result
);
	import ebtt_pkg::*;

	localparam int WOLD_BITS = ALPHA_BITS + 1;
	localparam int SUM_BITS  = BASELINE_BITS + WOLD_BITS + 1;
	localparam int POLD_BITS = BASELINE_BITS + WOLD_BITS;
	localparam int PNEW_BITS = ENERGY_BITS + ALPHA_BITS;

	cmd_t                     cmd;
	logic [BASELINE_BITS-1:0] target;
	logic [WOLD_BITS-1:0]     w_old;
	logic [POLD_BITS-1:0]     prod_old;
	logic [PNEW_BITS-1:0]     prod_new;
	logic [SUM_BITS-1:0]      sum;
	logic [BASELINE_BITS-1:0] blend;
	logic [BASELINE_BITS:0]   limit;
	logic                     over;
	logic [WARMUP_BITS-1:0]   cnt_inc;
	logic                     fire;

	assign cmd    = cmd_t'(item.command);
	assign target = {item.energy, {BASELINE_EXTRA_BITS{1'b0}}};

	// Rounded EMA: (old*(1-a) + target*a + half) >> 16
	assign w_old    = (WOLD_BITS)'(1 << ALPHA_BITS) - {1'b0, cfg.alpha};
	assign prod_old = {{WOLD_BITS{1'b0}}, cur.baseline} * {{BASELINE_BITS{1'b0}}, w_old};
	assign prod_new = {{ALPHA_BITS{1'b0}}, item.energy} * {{ENERGY_BITS{1'b0}}, cfg.alpha};
	assign sum   = {1'b0, prod_old}
	             + {{(SUM_BITS-PNEW_BITS-BASELINE_EXTRA_BITS){1'b0}}, prod_new,
	                {BASELINE_EXTRA_BITS{1'b0}}}
	             + SUM_BITS'(1 << (ALPHA_BITS - 1));
	assign blend = sum[ALPHA_BITS +: BASELINE_BITS];

	assign limit = {1'b0, cur.baseline}
	             + {1'b0, cfg.threshold, {BASELINE_EXTRA_BITS{1'b0}}};
	assign over  = {1'b0, target} > limit;

	assign cnt_inc = (cur.warmup_count != '1) ? cur.warmup_count + 1'b1 : cur.warmup_count;

	// next state
	always_comb begin
		nxt = cur;
		case (cmd)
			CMD_FEED: begin
				if (cur.mode == MODE_ARMED) begin
					if (!cur.baseline_ready) begin
						nxt.baseline       = (cur.warmup_count == '0) ? target : blend;
						nxt.warmup_count   = cnt_inc;
						nxt.baseline_ready = (cnt_inc >= cfg.warmup_frames);
					end else begin
						nxt.baseline = blend;
						if (over) begin
							nxt.mode = MODE_TRIGGERED;
							if (cur.trigger_total != '1) begin
								nxt.trigger_total = cur.trigger_total + 1'b1;
							end
							nxt.last_time   = item.timestamp;
							nxt.last_energy = item.energy;
						end
					end
				end
			end
			CMD_ARM: begin
				nxt.mode           = MODE_ARMED;
				nxt.baseline       = '0;
				nxt.warmup_count   = '0;
				nxt.baseline_ready = 1'b0;
			end
			CMD_DISARM: begin
				nxt.mode = MODE_IDLE;
			end
			CMD_REARM: begin
				if (cur.mode == MODE_TRIGGERED) begin
					nxt.mode           = MODE_ARMED;
					nxt.baseline       = '0;
					nxt.warmup_count   = '0;
					nxt.baseline_ready = 1'b0;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	// outputs
	always_comb begin
		fire = (cmd == CMD_FEED) && (cur.mode == MODE_ARMED) && cur.baseline_ready && over;
		result.fired            = fire;
		result.machine_state    = nxt.mode;
		result.warmed_up        = nxt.baseline_ready;
		result.fire_count       = nxt.trigger_total;
		result.last_fire_time   = nxt.last_time;
		result.last_fire_energy = nxt.last_energy;
	end

endmodule

`default_nettype wire
